// ----- rtl/core/shc_pkg.sv -----
// Shared types, constants and round functions of the SHA-256 hash core.
// Depends on nothing; the front end, back end, top level and testbench import it.
`timescale 1ns / 1ps

package shc_pkg;

    localparam logic [3:0] WORD_LAST  = 4'd15;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] DIGEST_LAST_IDX = 3'd7;

    localparam logic [31:0] IV_TABLE [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Classified message word as it travels from front to back.
    typedef struct packed {
        logic [31:0] word;
        logic        first;      // reload the initial hash first
        logic        block_end;  // sixteenth word of a block
        logic        emit;       // block end that also closes the message
    } t_q_entry;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PREP,
        ST_ROUND,
        ST_FINISH,
        ST_OUT
    } t_back_state;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

// ----- rtl/core/shc_if.sv -----
// Valid/ready channel interfaces for message words in and digest words out.
// Standalone; no package needed.
`timescale 1ns / 1ps

interface shc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] message_word;
    logic        first_word;
    logic        final_word;

    modport source (output valid, output message_word, output first_word,
                    output final_word, input ready);
    modport sink   (input valid, input message_word, input first_word,
                    input final_word, output ready);
endinterface

interface shc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;

    modport source (output valid, output digest_word, output digest_index,
                    output digest_last, input ready);
    modport sink   (input valid, input digest_word, input digest_index,
                    input digest_last, output ready);
endinterface

// ----- rtl/core/shc_front.sv -----
// Front end: accepts message words, tags block position, queues them.
// Depends on shc_pkg and shc_in_if.
`timescale 1ns / 1ps

module shc_front #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    shc_in_if.sink             i_msg,
    output logic               o_q_valid,
    output shc_pkg::t_q_entry  o_q_data,
    input  logic               i_q_ready
);
    import shc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_q_entry        r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_fill;
    logic [3:0]      r_word_cnt;

    logic            push;
    logic            pop;
    logic [3:0]      pos;
    t_q_entry        entry;

    assign i_msg.ready = (r_fill != CW'(DEPTH));
    assign push        = i_msg.valid && i_msg.ready;
    assign o_q_valid   = (r_fill != '0);
    assign pop         = o_q_valid && i_q_ready;
    assign o_q_data    = r_mem[r_rd];

    // A first word restarts the block count; a partial block is dropped.
    always_comb begin
        pos             = i_msg.first_word ? 4'd0 : r_word_cnt;
        entry.word      = i_msg.message_word;
        entry.first     = i_msg.first_word;
        entry.block_end = (pos == WORD_LAST);
        entry.emit      = (pos == WORD_LAST) && i_msg.final_word;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr       <= '0;
            r_rd       <= '0;
            r_fill     <= '0;
            r_word_cnt <= '0;
        end else begin
            if (push) begin
                r_wr       <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
                r_word_cnt <= pos + 4'd1;
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

// ----- rtl/core/shc_back.sv -----
// Back end: message window, round engine, chained hash and digest output.
// Depends on shc_pkg and shc_out_if.
`timescale 1ns / 1ps

module shc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  shc_pkg::t_q_entry  i_q_data,
    output logic               o_q_ready,
    shc_out_if.source          o_dig
);
    import shc_pkg::*;

    t_back_state  r_state;
    t_back_state  n_state;

    logic [31:0]  r_h [8];
    logic [31:0]  r_v [8];
    logic [31:0]  r_w [16];
    logic [31:0]  r_wk;
    logic [5:0]   r_round;
    logic [2:0]   r_idx;
    logic         r_emit;

    logic         pop;
    logic         out_take;
    logic         sched_step;
    logic [5:0]   sched_idx;
    logic [31:0]  sched_w;
    logic [31:0]  t1;
    logic [31:0]  t2;

    // State register and next-state logic.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_q_ready   = 1'b0;
        o_dig.valid = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_q_ready = 1'b1;
                if (i_q_valid && i_q_data.block_end) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                if (r_round == ROUND_LAST) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_state = r_emit ? ST_OUT : ST_LOAD;
            end
            ST_OUT: begin
                o_dig.valid = 1'b1;
                if (o_dig.ready && (r_idx == DIGEST_LAST_IDX)) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    assign pop      = o_q_ready && i_q_valid;
    assign out_take = o_dig.valid && o_dig.ready;

    // Schedule runs one word ahead of the rounds; W+K is registered.
    always_comb begin
        sched_step = (r_state == ST_PREP) ||
                     ((r_state == ST_ROUND) && (r_round != ROUND_LAST));
        sched_idx  = (r_state == ST_PREP) ? 6'd0 : r_round + 6'd1;
        if (sched_idx[5:4] == 2'b00) begin
            sched_w = r_w[0];
        end else begin
            sched_w = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];
        end
    end

    always_comb begin
        t1 = r_v[7] + big_sigma1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + r_wk;
        t2 = big_sigma0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // Window: shift in message words while loading, schedule words while rounding.
    always_ff @(posedge i_clk) begin
        if (pop || sched_step) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= pop ? i_q_data.word : sched_w;
        end
        if (sched_step) begin
            r_wk <= sched_w + K_TABLE[sched_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h     <= IV_TABLE;
            r_v     <= '{default: '0};
            r_round <= '0;
            r_idx   <= '0;
            r_emit  <= 1'b0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (pop) begin
                        if (i_q_data.first) begin
                            r_h <= IV_TABLE;
                        end
                        r_emit <= i_q_data.emit;
                    end
                end
                ST_PREP: begin
                    r_v     <= r_h;
                    r_round <= '0;
                end
                ST_ROUND: begin
                    r_v[7]  <= r_v[6];
                    r_v[6]  <= r_v[5];
                    r_v[5]  <= r_v[4];
                    r_v[4]  <= r_v[3] + t1;
                    r_v[3]  <= r_v[2];
                    r_v[2]  <= r_v[1];
                    r_v[1]  <= r_v[0];
                    r_v[0]  <= t1 + t2;
                    r_round <= r_round + 6'd1;
                end
                ST_FINISH: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    r_idx <= '0;
                end
                ST_OUT: begin
                    if (out_take) begin
                        r_idx <= r_idx + 3'd1;
                    end
                end
                default: begin
                    r_idx <= r_idx;
                end
            endcase
        end
    end

    assign o_dig.digest_word  = r_h[r_idx];
    assign o_dig.digest_index = r_idx;
    assign o_dig.digest_last  = (r_idx == DIGEST_LAST_IDX);

endmodule

// ----- rtl/core/sha256_hash_core.sv -----
// SHA-256 hash core top level: front queue plus round engine.
// Depends on shc_pkg, shc_if, shc_front and shc_back.
`timescale 1ns / 1ps
//
// Usage
//   i_msg carries padded message words, big-endian, one item per word.
//   first_word on an item reloads the initial hash and starts a block at
//   that word; a partly filled block is dropped. final_word counts only on
//   the sixteenth word of a block; elsewhere it is ignored.
//   o_dig carries the eight digest words, index 0 (most significant) first,
//   digest_last set on index 7.
// Timing
//   Words enter a QUEUE_DEPTH-entry queue and are loaded one per cycle while
//   the engine is in its load state. Each block then takes a setup step,
//   64 rounds (one round per cycle in a single round unit) and an add-back
//   step; the engine takes no new words until it is done. Digest word 0
//   appears once the closing block has passed setup, rounds and add-back.
// Stalls and reset
//   While digest words wait on o_dig the engine holds; the queue keeps
//   taking words until it is full. Reset empties the queue, loads the
//   initial hash and drops any digest in flight.
//
module sha256_hash_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    shc_in_if.sink      i_msg,
    shc_out_if.source   o_dig
);
    import shc_pkg::*;

    logic      q_valid;
    logic      q_ready;
    t_q_entry  q_data;

    // Accept and classify words, hold them until the engine is free.
    shc_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_msg     (i_msg),
        .o_q_valid (q_valid),
        .o_q_data  (q_data),
        .i_q_ready (q_ready)
    );

    // Absorb words, compress each block, stream out the digest.
    shc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_ready (q_ready),
        .o_dig     (o_dig)
    );

endmodule

// ----- rtl/core/shc_checker.sv -----
// Port-level checks on the digest channel of the hash core, bound to it.
// Depends on sha256_hash_core for the bind target.
`timescale 1ns / 1ps

module shc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_word,
    input logic [2:0]  i_out_index,
    input logic        i_out_last
);

    // Nothing comes out right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("digest valid right after reset");

    // Last mark and index agree.
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_last == (i_out_index == 3'd7)))
        else $error("digest_last does not match index 7");

    // Every digest starts at index 0.
    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> (i_out_index == 3'd0))
        else $error("digest did not start at index 0");

    // Words follow back to back in index order until the last one.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last) |=>
            (i_out_valid && (i_out_index == 3'($past(i_out_index) + 3'd1))))
        else $error("digest index did not advance");

    // A stalled word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_word) && $stable(i_out_index)))
        else $error("stalled digest word changed");

endmodule

bind sha256_hash_core shc_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_dig.valid),
    .i_out_ready (o_dig.ready),
    .i_out_word  (o_dig.digest_word),
    .i_out_index (o_dig.digest_index),
    .i_out_last  (o_dig.digest_last)
);

// ----- test/tb_sha256_hash_core.sv -----
// Self-checking testbench for sha256_hash_core: sends padded message words,
// predicts every digest with a local SHA-256 model and checks each digest word.
// Depends on shc_pkg, the shc_if channel interfaces and the core itself.
`timescale 1ns / 1ps

module tb_sha256_hash_core;
    import shc_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int MAX_IDLE     = 6;
    localparam int HOLD_CYCLES  = 400;      // long output stall, fills the input queue
    localparam int RANDOM_WORDS = 30;
    localparam int MIN_DIGESTS  = 2;
    localparam int DRAIN_CYCLES = 200;      // well past the digest latency
    localparam int RUN_LIMIT_NS = 500_000;

    // Standard SHA-256 starting hash and round constants, kept apart from the
    // package so that a wrong table in the design shows up as a mismatch.
    localparam logic [31:0] START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_item_t;

    logic clk;
    logic rst_n;

    shc_in_if  msg_bus ();
    shc_out_if dig_bus ();

    sha256_hash_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_msg   (msg_bus),
        .o_dig   (dig_bus)
    );

    // Hash predictor state: running hash, current block and position in it.
    logic [31:0]  hash_acc  [8];
    logic [31:0]  block_buf [16];
    logic [3:0]   block_pos;
    digest_item_t digest_fifo [$];

    // Traffic shaping for the sender and the digest drain; idle_on is shared by both.
    bit idle_on;
    bit hold_request;
    bit dig_taken;
    int ready_wait;

    int errors;
    int words_sent;
    int digests_expected;
    int digest_words_checked;
    int restarts_sent;
    int long_holds;

    initial begin : clock_gen
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Hash predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Run the 64 rounds on the buffered block, expanding the schedule in
    // place, and fold the result into the running hash.
    function automatic void compress_block_buf();
        logic [31:0] v [8];
        logic [31:0] w, x15, x2, s0, s1, ch, maj, t1, t2;
        for (int i = 0; i < 8; i++) v[i] = hash_acc[i];
        for (int t = 0; t < 64; t++) begin
            if (t < 16) begin
                w = block_buf[t];
            end else begin
                x15 = block_buf[(t - 15) & 15];
                x2  = block_buf[(t - 2) & 15];
                s0  = ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3);
                s1  = ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10);
                w   = s1 + block_buf[(t - 7) & 15] + s0 + block_buf[t & 15];
                block_buf[t & 15] = w;
            end
            ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
            maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t1  = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                + ch + ROUND_CONST[t] + w;
            t2  = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) + maj;
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_acc[i] = hash_acc[i] + v[i];
    endfunction

    // Absorb one accepted word; queue the eight digest words when it closes
    // a block and carries the end-of-message mark.
    function automatic void absorb_word(input logic [31:0] w, input logic start_msg,
                                        input logic end_msg);
        if (start_msg) begin
            for (int i = 0; i < 8; i++) hash_acc[i] = START_HASH[i];
            block_pos = '0;
        end
        block_buf[block_pos] = w;
        block_pos = block_pos + 4'd1;
        if (block_pos == 4'd0) begin
            compress_block_buf();
            if (end_msg) begin
                for (int k = 0; k < 8; k++)
                    digest_fifo.push_back(digest_item_t'{hash_acc[k], 3'(k),
                                            1'(k == int'(DIGEST_LAST_IDX))});
                digests_expected++;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Digest side: drive ready, check each accepted digest word
    // ------------------------------------------------------------------
    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: digest %s mismatch, expected %h, actual %h",
                     $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin : digest_check
        digest_item_t want;
        if (rst_n && dig_bus.valid && dig_bus.ready) begin
            dig_taken = 1'b1;
            digest_words_checked++;
            if (digest_fifo.size() == 0) begin
                $display("%0t ns: unexpected digest word, expected none, actual %h index %0d",
                         $time, dig_bus.digest_word, dig_bus.digest_index);
                errors++;
            end else begin
                want = digest_fifo.pop_front();
                check_field("word", want.word, dig_bus.digest_word);
                check_field("index", 32'(want.index), 32'(dig_bus.digest_index));
                check_field("last", 32'(want.last), 32'(dig_bus.digest_last));
            end
        end
    end

    // Draw a fresh stall after every taken digest word; a hold request
    // overrides it with one long stretch of ready low.
    always @(negedge clk) begin : digest_ready_drive
        if (!rst_n) begin
            dig_bus.ready <= 1'b0;
            ready_wait = 0;
        end else begin
            if (dig_taken) begin
                ready_wait = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
                dig_taken = 1'b0;
            end
            if (hold_request) begin
                ready_wait = HOLD_CYCLES;
                hold_request = 1'b0;
                long_holds++;
            end
            if (ready_wait > 0) begin
                dig_bus.ready <= 1'b0;
                ready_wait--;
            end else begin
                dig_bus.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Message side
    // ------------------------------------------------------------------
    // Idle for a drawn gap, offer one item, hold it until taken, then predict.
    task automatic send_word(input logic [31:0] w, input logic start_msg,
                             input logic end_msg);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        @(negedge clk);
        if (gap > 0) begin
            msg_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        msg_bus.valid        <= 1'b1;
        msg_bus.message_word <= w;
        msg_bus.first_word   <= start_msg;
        msg_bus.final_word   <= end_msg;
        do @(posedge clk); while (!msg_bus.ready);
        absorb_word(w, start_msg, end_msg);
        words_sent++;
        if (start_msg) restarts_sent++;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Whole message of random content; a stray end mark now and then lands
    // mid-block (ignored) or on an inner block end (early digest).
    task automatic send_message(input int blocks, input logic restart);
        int n_words;
        n_words = 16 * blocks;
        for (int i = 0; i < n_words; i++)
            send_word(rand_word(), restart && i == 0,
                      i == n_words - 1 || $urandom_range(0, 15) == 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Padded "abc" straight after reset, no start mark: reset must act as a
    // pending start. An end mark on word 3 does not close a block.
    task automatic test_known_vector();
        logic [31:0] w;
        for (int i = 0; i < 16; i++) begin
            w = (i == 0) ? 32'h6162_6380 : (i == 15) ? 32'h0000_0018 : 32'h0;
            send_word(w, 1'b0, i == 3 || i == 15);
        end
    endtask

    // Drop a partly filled block with a start mark, then hash a block of
    // alternating all-ones and all-zeros words.
    task automatic test_restart_mid_block();
        for (int i = 0; i < 4; i++)
            send_word(32'hffff_ffff, i == 0, i == 2);
        for (int i = 0; i < 16; i++)
            send_word((i % 2 == 0) ? 32'hffff_ffff : 32'h0, i == 0, i == 15);
    endtask

    // Keep chaining from the current hash after a digest, no start mark.
    task automatic test_chain_after_digest();
        send_message(1, 1'b0);
    endtask

    // Stall the digest side for a long stretch while words keep coming, so
    // the engine holds and the input queue backs up.
    task automatic test_output_backpressure();
        idle_on = 1'b0;
        hold_request = 1'b1;
        send_message(1, 1'b1);
        send_message(1, 1'b1);
        idle_on = 1'b1;
    endtask

    // Mostly well-formed messages of one or two blocks, some chained without
    // a start mark, mixed with broken partial blocks carrying stray marks.
    task automatic test_random_messages();
        int base_words, base_digests, pick, len;
        logic restart;
        base_words   = words_sent;
        base_digests = digests_expected;
        restart      = 1'b1;
        while (words_sent - base_words < RANDOM_WORDS
               || digests_expected - base_digests < MIN_DIGESTS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 7);
            if (pick == 0) begin
                len = $urandom_range(1, 15);
                for (int i = 0; i < len; i++)
                    send_word(rand_word(), i == 0 && $urandom_range(0, 1) == 1,
                              $urandom_range(0, 1) == 1);
                restart = 1'b1;
            end else begin
                send_message((pick == 1) ? 2 : 1, restart || pick != 2);
                restart = 1'b0;
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin : run_tests
        msg_bus.valid        = 1'b0;
        msg_bus.message_word = '0;
        msg_bus.first_word   = 1'b0;
        msg_bus.final_word   = 1'b0;
        dig_bus.ready        = 1'b0;
        rst_n                = 1'b0;
        idle_on              = 1'b1;
        hold_request         = 1'b0;
        dig_taken            = 1'b0;
        errors               = 0;
        words_sent           = 0;
        digests_expected     = 0;
        digest_words_checked = 0;
        restarts_sent        = 0;
        long_holds           = 0;
        block_pos            = '0;
        for (int i = 0; i < 8; i++) hash_acc[i] = START_HASH[i];

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_known_vector();
        test_restart_mid_block();
        test_chain_after_digest();
        test_output_backpressure();
        test_random_messages();

        @(negedge clk);
        msg_bus.valid <= 1'b0;
        while (digest_fifo.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d message words (%0d with a start mark), %0d digests",
                 words_sent, restarts_sent, digests_expected);
        $display("and %0d digest words checked, with %0d long output stall(s)",
                 digest_words_checked, long_holds);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("Timeout at %0t ns with %0d digest words still outstanding",
                 $time, digest_fifo.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sha256_hash_core.f -----
rtl/core/shc_pkg.sv
rtl/core/shc_if.sv
rtl/core/shc_front.sv
rtl/core/shc_back.sv
rtl/core/sha256_hash_core.sv
rtl/core/shc_checker.sv
test/tb_sha256_hash_core.sv
